FILE: rtl/core/mtswl_pkg.sv
// ----------------------------------------------------------------------------
// mtswl_pkg
// Shared types, constants and helpers of the multi-tier window limiter.
// ----------------------------------------------------------------------------
package mtswl_pkg;

    localparam int TIERS     = 3;
    localparam int LOG_DEPTH = 64;
    localparam int CFG_TIERS = 3;
    localparam int LOG_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int ADDR_W    = (TIERS * LOG_DEPTH > 1) ? $clog2(TIERS * LOG_DEPTH) : 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 31;

    localparam logic [30:0] WAIT_MAX   = 31'h7FFF_FFFF;
    localparam logic [47:0] STAMP_NONE = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] QUOTA_NONE = 17'h1FFFF;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_DONE   = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CONC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIER_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_C   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_A     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_B     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_C     = 3'd7;

    typedef struct packed {
        logic latch;
        logic dispatch;
        logic refresh;
        logic read;
        logic check;
        logic decide;
        logic log_wr;
        logic emit;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  pop;
        logic  last;
        logic  grant_ok;
        logic  out_free;
    } stat_t;

    function automatic logic [CNT_W-1:0] clamp_limit(input logic [15:0] v);
        if (v == 16'd0)
            return CNT_W'(1);
        else if (32'(v) > LOG_DEPTH)
            return CNT_W'(LOG_DEPTH);
        else
            return CNT_W'(v);
    endfunction

endpackage

FILE: rtl/core/mtswl_if.sv
// ----------------------------------------------------------------------------
// mtswl_if
// Request, response and configuration channels of the window limiter.
// ----------------------------------------------------------------------------
interface mtswl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [1:0]  tier_index;
    logic [15:0] server_limit;
    logic [15:0] server_left;
    logic signed [31:0] reset_delay_ms;
    logic [47:0] reset_stamp;

    modport source (output valid, mode, now_ms, tier_index, server_limit, server_left,
                    reset_delay_ms, reset_stamp, input ready);
    modport sink (input valid, mode, now_ms, tier_index, server_limit, server_left,
                  reset_delay_ms, reset_stamp, output ready);
endinterface

interface mtswl_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [30:0] wait_ms;
    logic [1:0]  status;

    modport source (output valid, granted, wait_ms, status, input ready);
    modport sink (input valid, granted, wait_ms, status, output ready);
endinterface

interface mtswl_cfg_if;
    logic        valid;
    logic        ready;
    logic [mtswl_pkg::CFG_IDX_W-1:0] index;
    logic [mtswl_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/mtswl_datapath.sv
// ----------------------------------------------------------------------------
// mtswl_datapath
// Tier state, start log memory, wait arithmetic and result registers.
// ----------------------------------------------------------------------------
module mtswl_datapath (
    input  logic                clk,
    input  logic                rst_n,
    mtswl_req_if.sink           req,
    mtswl_rsp_if.source         rsp,
    mtswl_cfg_if.sink           cfg,
    input  mtswl_pkg::cmd_t     cmd,
    output mtswl_pkg::stat_t    stat
);
    localparam int CNT_W  = mtswl_pkg::CNT_W;
    localparam int LOG_W  = mtswl_pkg::LOG_W;
    localparam int ADDR_W = mtswl_pkg::ADDR_W;
    localparam int TIERS  = mtswl_pkg::TIERS;

    // configuration
    logic [7:0]  max_conc_reg;
    logic [1:0]  tier_cnt_reg;
    logic [30:0] win_ms_reg [mtswl_pkg::CFG_TIERS];

    // latched request
    mtswl_pkg::mode_t mode_reg;
    logic [31:0] now_reg;
    logic [1:0]  ti_reg;
    logic [15:0] lim_reg;
    logic [15:0] left_reg;
    logic [31:0] rd_reg;
    logic [47:0] stamp_reg;

    // tier state
    logic [LOG_W-1:0] head_reg     [TIERS];
    logic [CNT_W-1:0] count_reg    [TIERS];
    logic [CNT_W-1:0] live_reg     [TIERS];
    logic [16:0]      quota_reg    [TIERS];
    logic [31:0]      deadline_reg [TIERS];
    logic             dv_reg       [TIERS];
    logic [47:0]      qstamp_reg   [TIERS];
    logic [7:0]       running_reg;

    logic [1:0]  tier_reg;
    logic [30:0] wait_reg;
    logic        res_granted_reg;
    logic [1:0]  res_status_reg;

    logic        out_valid_reg;
    logic        out_granted_reg;
    logic [30:0] out_wait_reg;
    logic [1:0]  out_status_reg;

    logic [31:0] log_mem [TIERS * mtswl_pkg::LOG_DEPTH];
    logic [31:0] mem_q_reg;

    logic [1:0]  used_n;
    logic [30:0] iv;
    logic [31:0] diff_nd;
    logic [31:0] diff_dn;
    logic        expired;
    logic        qwait;
    logic [31:0] age;
    logic [31:0] lim_d;
    logic [30:0] lim_w;
    logic        lim_hit;
    logic        pop;
    logic [LOG_W-1:0] head_inc;
    logic        full;
    logic [LOG_W-1:0] wr_head;
    logic [CNT_W-1:0] wr_count;
    logic [CNT_W:0]   wr_sum;
    logic [LOG_W-1:0] wr_off;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic        reject;
    logic        cfg_wr;

    assign cfg.ready = 1'b1;
    assign req.ready = cmd.latch;
    assign cfg_wr    = cfg.valid;

    always_comb
    begin
        if (tier_cnt_reg == 2'd0)
            used_n = 2'd1;
        else if (32'(tier_cnt_reg) > TIERS)
            used_n = 2'(TIERS);
        else
            used_n = tier_cnt_reg;
    end

    always_comb
    begin
        iv = (win_ms_reg[tier_reg] == 31'd0) ? 31'd1 : win_ms_reg[tier_reg];
    end

    assign diff_nd = now_reg - deadline_reg[tier_reg];
    assign diff_dn = deadline_reg[tier_reg] - now_reg;
    assign expired = dv_reg[tier_reg] && !diff_nd[31];
    assign qwait   = !expired && dv_reg[tier_reg] && (quota_reg[tier_reg] == 17'd0)
                     && !diff_dn[31] && (diff_dn != 32'd0);

    assign age     = now_reg - mem_q_reg;
    assign pop     = (count_reg[tier_reg] != '0) && (age >= {1'b0, iv});
    assign lim_hit = (count_reg[tier_reg] != '0) && (count_reg[tier_reg] >= live_reg[tier_reg]);
    assign lim_d   = {1'b0, iv} - age;
    assign lim_w   = lim_d[31] ? mtswl_pkg::WAIT_MAX : lim_d[30:0];

    assign head_inc = (32'(head_reg[tier_reg]) == mtswl_pkg::LOG_DEPTH - 1)
                      ? '0 : head_reg[tier_reg] + LOG_W'(1);
    assign full     = (32'(count_reg[tier_reg]) >= mtswl_pkg::LOG_DEPTH);
    assign wr_head  = full ? head_inc : head_reg[tier_reg];
    assign wr_count = full ? count_reg[tier_reg] - CNT_W'(1) : count_reg[tier_reg];
    assign wr_sum   = (CNT_W + 1)'(wr_head) + (CNT_W + 1)'(wr_count);
    assign wr_off   = (32'(wr_sum) >= mtswl_pkg::LOG_DEPTH)
                      ? LOG_W'(32'(wr_sum) - mtswl_pkg::LOG_DEPTH) : LOG_W'(wr_sum);

    assign rd_addr = ADDR_W'(32'(tier_reg) * mtswl_pkg::LOG_DEPTH + 32'(head_reg[tier_reg]));
    assign wr_addr = ADDR_W'(32'(tier_reg) * mtswl_pkg::LOG_DEPTH + 32'(wr_off));

    assign reject = (ti_reg >= used_n) || (lim_reg == 16'd0) || (left_reg > lim_reg);

    always_comb
    begin
        stat.mode     = mode_reg;
        stat.pop      = pop;
        stat.last     = (tier_reg == used_n - 2'd1);
        stat.grant_ok = (running_reg < max_conc_reg) && (wait_reg == 31'd0);
        stat.out_free = !out_valid_reg || rsp.ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
            mem_q_reg <= log_mem[rd_addr];
        if (cmd.log_wr)
            log_mem[wr_addr] <= now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_conc_reg    <= 8'd1;
            tier_cnt_reg    <= 2'd1;
            for (int i = 0; i < mtswl_pkg::CFG_TIERS; i++)
                win_ms_reg[i] <= 31'd1000;
            for (int i = 0; i < TIERS; i++)
            begin
                head_reg[i]     <= '0;
                count_reg[i]    <= '0;
                live_reg[i]     <= CNT_W'(1);
                quota_reg[i]    <= mtswl_pkg::QUOTA_NONE;
                deadline_reg[i] <= 32'd0;
                dv_reg[i]       <= 1'b0;
                qstamp_reg[i]   <= mtswl_pkg::STAMP_NONE;
            end
            running_reg     <= 8'd0;
            tier_reg        <= 2'd0;
            wait_reg        <= 31'd0;
            res_granted_reg <= 1'b0;
            res_status_reg  <= mtswl_pkg::ST_OK;
            mode_reg        <= mtswl_pkg::MODE_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg.index) inside
                    mtswl_pkg::REG_MAX_CONC: max_conc_reg <= cfg.data[7:0];
                    mtswl_pkg::REG_TIER_CNT: tier_cnt_reg <= cfg.data[1:0];
                    mtswl_pkg::REG_LIMIT_A, mtswl_pkg::REG_LIMIT_B, mtswl_pkg::REG_LIMIT_C:
                    begin
                        if (32'(cfg.index - mtswl_pkg::REG_LIMIT_A) < TIERS)
                            live_reg[2'(cfg.index - mtswl_pkg::REG_LIMIT_A)] <=
                                mtswl_pkg::clamp_limit({9'd0, cfg.data[6:0]});
                    end
                    mtswl_pkg::REG_WIN_A, mtswl_pkg::REG_WIN_B, mtswl_pkg::REG_WIN_C:
                        win_ms_reg[2'(cfg.index - mtswl_pkg::REG_WIN_A)] <= cfg.data;
                    default: ;
                endcase
            end

            if (cmd.latch && req.valid)
            begin
                mode_reg        <= mtswl_pkg::mode_t'(req.mode);
                now_reg         <= req.now_ms;
                ti_reg          <= req.tier_index;
                lim_reg         <= req.server_limit;
                left_reg        <= req.server_left;
                rd_reg          <= req.reset_delay_ms;
                stamp_reg       <= req.reset_stamp;
                tier_reg        <= 2'd0;
                wait_reg        <= 31'd0;
                res_granted_reg <= 1'b0;
                res_status_reg  <= mtswl_pkg::ST_OK;
            end

            if (cmd.dispatch)
            begin
                case (mode_reg)
                    mtswl_pkg::MODE_DONE:
                        if (running_reg != 8'd0)
                            running_reg <= running_reg - 8'd1;
                    mtswl_pkg::MODE_UPDATE:
                    begin
                        if (reject)
                            res_status_reg <= mtswl_pkg::ST_REJECT;
                        else
                        begin
                            live_reg[ti_reg]  <= mtswl_pkg::clamp_limit(lim_reg);
                            head_reg[ti_reg]  <= '0;
                            count_reg[ti_reg] <= '0;
                            if (rd_reg != 32'd0 && !rd_reg[31])
                            begin
                                if (qstamp_reg[ti_reg] == stamp_reg && !quota_reg[ti_reg][16])
                                begin
                                    if (quota_reg[ti_reg] > {1'b0, left_reg})
                                        quota_reg[ti_reg] <= {1'b0, left_reg};
                                end
                                else
                                    quota_reg[ti_reg] <= {1'b0, left_reg};
                                deadline_reg[ti_reg] <= now_reg + rd_reg;
                                dv_reg[ti_reg]       <= 1'b1;
                                qstamp_reg[ti_reg]   <= stamp_reg;
                            end
                            else
                            begin
                                quota_reg[ti_reg]    <= mtswl_pkg::QUOTA_NONE;
                                deadline_reg[ti_reg] <= 32'd0;
                                dv_reg[ti_reg]       <= 1'b0;
                                qstamp_reg[ti_reg]   <= mtswl_pkg::STAMP_NONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.refresh)
            begin
                if (expired)
                begin
                    head_reg[tier_reg]     <= '0;
                    count_reg[tier_reg]    <= '0;
                    quota_reg[tier_reg]    <= mtswl_pkg::QUOTA_NONE;
                    deadline_reg[tier_reg] <= 32'd0;
                    dv_reg[tier_reg]       <= 1'b0;
                    qstamp_reg[tier_reg]   <= mtswl_pkg::STAMP_NONE;
                end
                if (qwait && diff_dn[30:0] > wait_reg)
                    wait_reg <= diff_dn[30:0];
            end

            if (cmd.check)
            begin
                if (pop)
                begin
                    head_reg[tier_reg]  <= head_inc;
                    count_reg[tier_reg] <= count_reg[tier_reg] - CNT_W'(1);
                end
                else
                begin
                    if (lim_hit && lim_w > wait_reg)
                        wait_reg <= lim_w;
                    tier_reg <= tier_reg + 2'd1;
                end
            end

            if (cmd.decide)
            begin
                tier_reg <= 2'd0;
                if (running_reg >= max_conc_reg)
                    res_status_reg <= mtswl_pkg::ST_BUSY;
                else if (wait_reg != 31'd0)
                    res_status_reg <= mtswl_pkg::ST_WAIT;
                else
                begin
                    res_granted_reg <= 1'b1;
                    running_reg     <= running_reg + 8'd1;
                end
            end

            if (cmd.log_wr)
            begin
                head_reg[tier_reg]  <= wr_head;
                count_reg[tier_reg] <= wr_count + CNT_W'(1);
                if (!quota_reg[tier_reg][16] && quota_reg[tier_reg] != 17'd0)
                    quota_reg[tier_reg] <= quota_reg[tier_reg] - 17'd1;
                tier_reg <= tier_reg + 2'd1;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_granted_reg <= res_granted_reg;
            out_wait_reg    <= (mode_reg == mtswl_pkg::MODE_START) ? wait_reg : 31'd0;
            out_status_reg  <= res_status_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.granted = out_granted_reg;
    assign rsp.wait_ms = out_wait_reg;
    assign rsp.status  = out_status_reg;

endmodule

FILE: rtl/core/mtswl_ctrl.sv
// ----------------------------------------------------------------------------
// mtswl_ctrl
// Sequencer of the window limiter: walks tiers, purges logs, logs grants.
// ----------------------------------------------------------------------------
module mtswl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  mtswl_pkg::stat_t  stat,
    output mtswl_pkg::cmd_t   cmd
);
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_REFRESH  = 8'b0000_0100,
        S_READ     = 8'b0000_1000,
        S_CHECK    = 8'b0001_0000,
        S_DECIDE   = 8'b0010_0000,
        S_LOG      = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = 1'b1;
                if (req_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                state_next   = (stat.mode == mtswl_pkg::MODE_START) ? S_REFRESH : S_RESULT;
            end
            S_REFRESH:
            begin
                cmd.refresh = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.pop)
                    state_next = S_READ;
                else if (stat.last)
                    state_next = S_DECIDE;
                else
                    state_next = S_REFRESH;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.grant_ok ? S_LOG : S_RESULT;
            end
            S_LOG:
            begin
                cmd.log_wr = 1'b1;
                if (stat.last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/core/multi_tier_sliding_window_limiter.sv
// ----------------------------------------------------------------------------
// multi_tier_sliding_window_limiter
// Admission controller with up to three sliding-window rate tiers.
// ----------------------------------------------------------------------------
// One request is handled at a time. A job-finished event or a server update
// passes through the dispatch and result states. A start request passes
// through dispatch, then for each tier in use a refresh, a read and a check,
// with one more read and check for every expired start purged from that
// tier's log, then a decide and, when granted, one log write per tier in
// use, and last the result. Every purge step is one read of the start log
// memory and one compare, the memory having a single registered read port.
// The response sits in an output register, so the next request is taken
// while it waits; the start log needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module multi_tier_sliding_window_limiter (
    input  logic        clk,
    input  logic        rst_n,
    mtswl_req_if.sink   req,
    mtswl_rsp_if.source rsp,
    mtswl_cfg_if.sink   cfg
);
    mtswl_pkg::cmd_t  cmd;
    mtswl_pkg::stat_t stat;

    // sequencer: issue one datapath command per cycle, none while the result waits for a free output register
    mtswl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tier state, log memory and result registers
    mtswl_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
